@@ rtl/etr_pkg.sv @@
// Shared types and constants for the ethertype packet router.
package etr_pkg;

	// Destination port codes
	localparam logic [1:0] PORT_ARP   = 2'd0;
	localparam logic [1:0] PORT_IPV4  = 2'd1;
	localparam logic [1:0] PORT_OTHER = 2'd2;

	// Configuration register indexes
	localparam logic CFG_ARP_TYPE  = 1'b0;
	localparam logic CFG_IPV4_TYPE = 1'b1;

	localparam logic [15:0] ARP_TYPE_RST  = 16'h0806;
	localparam logic [15:0] IPV4_TYPE_RST = 16'h0800;

	// Result queue geometry
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	typedef struct packed {
		logic [63:0] data;
		logic        start;
		logic        fin;
		logic [2:0]  empty;
	} etr_beat_t;

	typedef struct packed {
		logic [1:0]  port;
		logic [63:0] data;
		logic        start;
		logic        fin;
		logic [2:0]  empty;
		logic        last;
	} etr_result_t;

	// Results produced by one accepted beat (count is 0, 1 or 2)
	typedef struct packed {
		logic [1:0]  count;
		etr_result_t first;
		etr_result_t second;
	} etr_push_t;

endpackage

@@ rtl/etr_classify.sv @@
// Packet phase tracking, held first beat and ethertype compare.
module etr_classify import etr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  etr_beat_t   beat,
	input  logic [15:0] arp_type,
	input  logic [15:0] ipv4_type,
	output etr_push_t   push
);

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HELD   = 2'd1,
		PH_STREAM = 2'd2
	} phase_t;

	phase_t      phase_q;
	phase_t      phase_nx;
	logic [1:0]  route_q;
	logic [1:0]  route_nx;
	logic [1:0]  match_route;
	logic [15:0] etype;
	logic        load_held;
	logic [63:0] held_data_q;
	logic        held_start_q;
	logic [2:0]  held_empty_q;

	assign etype = beat.data[31:16];

	// ARP compare wins when both types are equal
	always_comb begin
		if (etype == arp_type) begin
			match_route = PORT_ARP;
		end else if (etype == ipv4_type) begin
			match_route = PORT_IPV4;
		end else begin
			match_route = PORT_OTHER;
		end
	end

	always_comb begin
		push      = '0;
		phase_nx  = phase_q;
		route_nx  = route_q;
		load_held = 1'b0;
		unique case (phase_q)
			PH_HELD: begin
				push.count  = 2'd2;
				push.first  = '{port: match_route, data: held_data_q, start: held_start_q,
					fin: 1'b0, empty: held_empty_q, last: 1'b0};
				push.second = '{port: match_route, data: beat.data, start: beat.start,
					fin: beat.fin, empty: beat.empty, last: 1'b1};
				route_nx    = match_route;
				phase_nx    = beat.fin ? PH_IDLE : PH_STREAM;
			end
			PH_STREAM: begin
				push.count = 2'd1;
				push.first = '{port: route_q, data: beat.data, start: beat.start,
					fin: beat.fin, empty: beat.empty, last: 1'b1};
				if (beat.fin) begin
					phase_nx = PH_IDLE;
				end
			end
			default: begin
				if (beat.fin) begin
					// single-beat packet goes straight out
					push.count = 2'd1;
					push.first = '{port: PORT_OTHER, data: beat.data, start: beat.start,
						fin: beat.fin, empty: beat.empty, last: 1'b1};
					route_nx   = PORT_OTHER;
					phase_nx   = PH_IDLE;
				end else begin
					load_held = 1'b1;
					phase_nx  = PH_HELD;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			route_q <= PORT_OTHER;
		end else if (accept) begin
			phase_q <= phase_nx;
			route_q <= route_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && load_held) begin
			held_data_q  <= beat.data;
			held_start_q <= beat.start;
			held_empty_q <= beat.empty;
		end
	end

endmodule

@@ rtl/ethertype_packet_router_top.sv @@
// Top level of the ethertype packet router: config registers and result queue.
//
// Ethertype packet router. Tags each 64-bit frame beat with a destination port
// (0 ARP, 1 IPv4, 2 other). The first beat of a packet is held; when the second
// beat arrives its bits 31:16 are compared with arp_type, then ipv4_type, and
// both beats are sent on the chosen port; later beats follow on that port up to
// the end flag. A packet start is the first beat after reset or after an end
// flag - start_flag is forwarded but never checked. A one-beat packet goes to
// the other port at once. Rate: one beat per cycle sustained while the output is
// not stalled; the classifier sits between the input transfer and a four-entry
// result queue, so a result can be taken the cycle after its beat. The second
// beat of each packet pushes two results and the first pushes none, so with the
// output never stalled the queue holds at most two results and the input is
// never stalled. in_stall is high when fewer than two queue slots are free,
// which only happens once output stalls have backed the queue up to three or
// more results. Config writes are taken on every cycle (cfg_ready is tied high)
// and are meant for when the block is idle.
module ethertype_packet_router_top import etr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// input beats
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] beat_data,
	input  logic        start_flag,
	input  logic        end_flag,
	input  logic [2:0]  empty_bytes,
	// tagged results
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  port,
	output logic [63:0] out_data,
	output logic        out_start,
	output logic        out_end,
	output logic [2:0]  out_empty,
	output logic        last
);

	logic [15:0]  arp_type_q;
	logic [15:0]  ipv4_type_q;
	logic         in_xfer;
	logic         out_xfer;
	etr_beat_t    beat;
	etr_push_t    push;
	logic [1:0]   n_push;
	etr_result_t  queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] wr_ptr_inc;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	etr_result_t  head;

	// Config registers - always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arp_type_q  <= ARP_TYPE_RST;
			ipv4_type_q <= IPV4_TYPE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ARP_TYPE:  arp_type_q  <= cfg_data;
				CFG_IPV4_TYPE: ipv4_type_q <= cfg_data;
				default:       arp_type_q  <= arp_type_q;
			endcase
		end
	end

	// Input side: stall only when the queue cannot take a two-result push
	assign in_stall = (cnt_q > QCNT_W'(QUEUE_DEPTH - 2));
	assign in_xfer  = in_valid && !in_stall;

	assign beat = '{data: beat_data, start: start_flag, fin: end_flag, empty: empty_bytes};

	etr_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_xfer),
		.beat      (beat),
		.arp_type  (arp_type_q),
		.ipv4_type (ipv4_type_q),
		.push      (push)
	);

	assign n_push     = in_xfer ? push.count : 2'd0;
	assign wr_ptr_inc = wr_ptr_q + QPTR_W'(1);

	// Result queue; up to two writes per transfer, one read per output transfer
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			queue_q[wr_ptr_q] <= push.first;
		end
		if (n_push == 2'd2) begin
			queue_q[wr_ptr_inc] <= push.second;
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_xfer  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
			if (out_xfer) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(n_push) - QCNT_W'(out_xfer);
		end
	end

	assign head      = queue_q[rd_ptr_q];
	assign port      = head.port;
	assign out_data  = head.data;
	assign out_start = head.start;
	assign out_end   = head.fin;
	assign out_empty = head.empty;
	assign last      = head.last;

`ifndef SYNTHESIS
	// queue occupancy never passes its depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overflow");

	// a stalled result is not dropped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result lost");

	// only the last result of a beat can carry the end marker
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !out_end)
		else $error("end marker on a held beat");

	// port code is always a real destination
	a_port: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (port == PORT_ARP || port == PORT_IPV4 || port == PORT_OTHER))
		else $error("bad port code");
`endif

endmodule
